### hdl/rmeter_pkg.sv
// ----------------------------------------------------------------------------
// rmeter_pkg
// Shared widths, codes and types of the autoranging resistance meter.
// ----------------------------------------------------------------------------
`default_nettype none

package rmeter_pkg;

    // Range bounds
    localparam int MAX_LEVEL = 3;
    localparam int MAX_GAIN  = 7;
    localparam logic [1:0] LEVEL_LAST = 2'((MAX_LEVEL < 3) ? MAX_LEVEL : 3);
    localparam logic [2:0] GAIN_LAST  = 3'((MAX_GAIN < 7) ? MAX_GAIN : 7);

    // Datapath widths
    localparam int UV_W      = 31;              // non-negative reading
    localparam int RES_W     = 31;              // calibration resistance
    localparam int PROD_W    = UV_W + RES_W;    // r * uV
    localparam int VALUE_W   = 63;
    localparam int MUL_STEPS = UV_W;            // one multiplier bit per cycle
    localparam int DIV_STEPS = PROD_W;          // one quotient bit per cycle
    localparam int MCNT_W    = $clog2(MUL_STEPS);
    localparam int DCNT_W    = $clog2(DIV_STEPS);
    localparam int TAB_AW    = 5;               // {level, gain}
    localparam int TAB_DEPTH = 1 << TAB_AW;

    // Stream widths
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 88;
    localparam int CFG_W       = 31;

    // Reset values
    localparam logic [UV_W-1:0]    THRESH_RESET = 31'd125000;
    localparam logic [VALUE_W-1:0] OPEN_VALUE   = '1;

    // Input actions
    localparam logic [1:0] ACT_START   = 2'd0;
    localparam logic [1:0] ACT_READING = 2'd1;
    localparam logic [1:0] ACT_CAL     = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_REQ      = 2'd0;
    localparam logic [1:0] KIND_MEAS     = 2'd1;
    localparam logic [1:0] KIND_CAL_DONE = 2'd2;
    localparam logic [1:0] KIND_ERR      = 2'd3;

    // Error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_FAULT    = 3'd1;
    localparam logic [2:0] ERR_CAL_OVF  = 3'd2;
    localparam logic [2:0] ERR_CAL_NEG  = 3'd3;
    localparam logic [2:0] ERR_ZERO_DIV = 3'd5;

    // Register indexes
    localparam logic [2:0] CFG_THRESHOLD = 3'd0;
    localparam logic [2:0] CFG_DAC0      = 3'd1;
    localparam logic [2:0] CFG_DAC1      = 3'd2;
    localparam logic [2:0] CFG_DAC2      = 3'd3;
    localparam logic [2:0] CFG_DAC3      = 3'd4;

    // Operating mode
    typedef enum logic [2:0] {
        MODE_IDLE = 3'b001,
        MODE_MEAS = 3'b010,
        MODE_CAL  = 3'b100
    } t_mode;

    // Sequencer state
    typedef enum logic [4:0] {
        SEQ_IDLE = 5'b00001,
        SEQ_LOAD = 5'b00010,
        SEQ_MUL  = 5'b00100,
        SEQ_DIV  = 5'b01000,
        SEQ_WAIT = 5'b10000
    } t_seq;

    // Calibration table access
    typedef struct packed {
        logic              we;
        logic              re;
        logic [TAB_AW-1:0] addr;
    } t_mem_req;

endpackage

`default_nettype wire

### hdl/rmeter_cal_mem.sv
// ----------------------------------------------------------------------------
// rmeter_cal_mem
// Calibration tables: reference resistance and measured reading per entry.
// ----------------------------------------------------------------------------
`default_nettype none

module rmeter_cal_mem (
    input  wire logic                            i_clk,
    input  wire rmeter_pkg::t_mem_req            i_req,
    input  wire logic [rmeter_pkg::RES_W-1:0]    i_wr_res,
    input  wire logic [rmeter_pkg::UV_W-1:0]     i_wr_reading,
    output logic      [rmeter_pkg::RES_W-1:0]    o_rd_res,
    output logic      [rmeter_pkg::UV_W-1:0]     o_rd_reading
);

    logic [rmeter_pkg::RES_W-1:0] r_res_mem [rmeter_pkg::TAB_DEPTH];
    logic [rmeter_pkg::UV_W-1:0]  r_rd_mem  [rmeter_pkg::TAB_DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_res_mem[i_req.addr] <= i_wr_res;
            r_rd_mem[i_req.addr]  <= i_wr_reading;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            o_rd_res     <= r_res_mem[i_req.addr];
            o_rd_reading <= r_rd_mem[i_req.addr];
        end
    end

endmodule

`default_nettype wire

### hdl/rmeter_mul.sv
// ----------------------------------------------------------------------------
// rmeter_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rmeter_mul (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic [rmeter_pkg::RES_W-1:0]     i_a,
    input  wire logic [rmeter_pkg::UV_W-1:0]      i_b,
    output logic                                  o_done,
    output logic      [rmeter_pkg::PROD_W-1:0]    o_product
);

    logic                           r_busy;
    logic [rmeter_pkg::MCNT_W-1:0]  r_cnt;
    logic [rmeter_pkg::RES_W-1:0]   r_a;
    logic [rmeter_pkg::RES_W-1:0]   r_hi;
    logic [rmeter_pkg::UV_W-1:0]    r_lo;
    logic [rmeter_pkg::RES_W:0]     n_sum;
    logic                           w_last;

    // Partial sum: add multiplicand when the low bit is set
    assign n_sum  = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : '0);
    assign w_last = (r_cnt == rmeter_pkg::MCNT_W'(rmeter_pkg::MUL_STEPS - 1));

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    // Product register shifts right one bit per step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_a;
            r_hi <= '0;
            r_lo <= i_b;
        end else if (r_busy) begin
            r_hi <= n_sum[rmeter_pkg::RES_W:1];
            r_lo <= {n_sum[0], r_lo[rmeter_pkg::UV_W-1:1]};
        end
    end

    assign o_product = {r_hi, r_lo};

endmodule

`default_nettype wire

### hdl/rmeter_div.sv
// ----------------------------------------------------------------------------
// rmeter_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rmeter_div (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic [rmeter_pkg::PROD_W-1:0]    i_dividend,
    input  wire logic [rmeter_pkg::UV_W-1:0]      i_divisor,
    output logic                                  o_done,
    output logic      [rmeter_pkg::PROD_W-1:0]    o_quotient
);

    logic                           r_busy;
    logic [rmeter_pkg::DCNT_W-1:0]  r_cnt;
    logic [rmeter_pkg::UV_W-1:0]    r_d;
    logic [rmeter_pkg::UV_W-1:0]    r_rem;
    logic [rmeter_pkg::PROD_W-1:0]  r_q;
    logic [rmeter_pkg::UV_W:0]      w_trial;
    logic [rmeter_pkg::UV_W:0]      w_diff;
    logic                           w_ge;
    logic                           w_last;

    // Trial subtract of the shifted remainder
    assign w_trial = {r_rem, r_q[rmeter_pkg::PROD_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_d});
    assign w_diff  = w_trial - {1'b0, r_d};
    assign w_last  = (r_cnt == rmeter_pkg::DCNT_W'(rmeter_pkg::DIV_STEPS - 1));

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    // Dividend bits leave at the top, quotient bits enter at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_d   <= i_divisor;
            r_rem <= '0;
            r_q   <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[rmeter_pkg::UV_W-1:0] : w_trial[rmeter_pkg::UV_W-1:0];
            r_q   <= {r_q[rmeter_pkg::PROD_W-2:0], w_ge};
        end
    end

    assign o_quotient = r_q;

endmodule

`default_nettype wire

### hdl/autorange_resistance_meter.sv
// ----------------------------------------------------------------------------
// autorange_resistance_meter
// Autoranging resistance measurement sequencer with calibration tables.
// ----------------------------------------------------------------------------
// A start or calibration request, and every reading that leads to another
// reading request, is answered from the output register in the cycle after it
// is accepted. A reading that fixes the range starts the result computation:
// a table read, a load and 31 steps in the bit-serial multiplier, a load and
// 62 steps in the restoring divider, and the hand-over of the quotient to the
// output register. A zero calibration reading ends the computation after the
// table read and goes straight to the hand-over. The input side takes a
// new request only while the sequencer is idle and the output register is
// empty or being emptied in the same cycle. Calibration entries read back
// before they are ever written return unspecified data.
`default_nettype none

module autorange_resistance_meter (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // configuration
    input  wire logic                                  i_cfg_wr_en,
    input  wire logic [2:0]                            i_cfg_addr,
    input  wire logic [rmeter_pkg::CFG_W-1:0]          i_cfg_wdata,
    // input stream
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // reading_uv[31:0], reading_overflow[32], reading_fault[33],
    // cal_level[35:34], cal_gain[38:36], cal_resistance[69:39]
    input  wire logic [rmeter_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // action[1:0]
    input  wire logic [1:0]                            s_axis_tuser,
    // output stream
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // dac_code[11:0], gain_select[14:12], level_index[16:15],
    // value[79:17], error_code[82:80]
    output logic      [rmeter_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // kind[1:0]
    output logic      [1:0]                            m_axis_tuser
);

    // Configuration registers
    logic [rmeter_pkg::UV_W-1:0] r_thr;
    logic [11:0]                 r_dac [4];

    // Sequencer state
    rmeter_pkg::t_mode r_mode, n_mode;
    rmeter_pkg::t_seq  r_seq,  n_seq;
    logic [1:0]                   r_level, n_level;
    logic [2:0]                   r_gain,  n_gain;
    logic                         r_ranging, n_ranging;
    logic                         r_zero, n_zero;
    logic [rmeter_pkg::RES_W-1:0] r_pending, n_pending;
    logic [rmeter_pkg::UV_W-1:0]  r_uv, n_uv;

    // Output register
    logic                            r_out_valid;
    logic [1:0]                      r_out_kind;
    logic [11:0]                     r_out_dac;
    logic [2:0]                      r_out_gain;
    logic [1:0]                      r_out_level;
    logic [rmeter_pkg::VALUE_W-1:0]  r_out_value;
    logic [2:0]                      r_out_err;

    // Request fields
    logic [1:0]                      in_action;
    logic [31:0]                     in_raw;
    logic                            in_ovf;
    logic                            in_fault;
    logic [1:0]                      in_cal_level;
    logic [2:0]                      in_cal_gain;
    logic [rmeter_pkg::RES_W-1:0]    in_cal_res;
    logic                            in_neg;
    logic [rmeter_pkg::UV_W-1:0]     in_uv;

    logic                            w_fire;
    logic                            w_out_free;
    logic                            w_below;
    logic                            w_lvl_bound;
    logic                            w_gain_bound;

    // Emitted result
    logic                            e_emit;
    logic [1:0]                      e_kind;
    logic [rmeter_pkg::VALUE_W-1:0]  e_value;
    logic [2:0]                      e_err;

    // Arithmetic units and tables
    rmeter_pkg::t_mem_req            w_mem_req;
    logic [rmeter_pkg::RES_W-1:0]    w_rd_res;
    logic [rmeter_pkg::UV_W-1:0]     w_rd_reading;
    logic                            w_mul_start, w_mul_done;
    logic [rmeter_pkg::PROD_W-1:0]   w_product;
    logic                            w_div_start, w_div_done;
    logic [rmeter_pkg::PROD_W-1:0]   w_quotient;

    // Unpack input
    assign in_action    = s_axis_tuser;
    assign in_raw       = s_axis_tdata[31:0];
    assign in_ovf       = s_axis_tdata[32];
    assign in_fault     = s_axis_tdata[33];
    assign in_cal_level = s_axis_tdata[35:34];
    assign in_cal_gain  = s_axis_tdata[38:36];
    assign in_cal_res   = s_axis_tdata[69:39];
    assign in_neg       = in_raw[31];
    assign in_uv        = in_neg ? '0 : in_raw[rmeter_pkg::UV_W-1:0];

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_seq == rmeter_pkg::SEQ_IDLE) && w_out_free;
    assign w_fire        = s_axis_tvalid && s_axis_tready;

    assign w_below      = (in_uv < r_thr);
    assign w_lvl_bound  = (r_level >= rmeter_pkg::LEVEL_LAST);
    assign w_gain_bound = (r_gain >= rmeter_pkg::GAIN_LAST);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= rmeter_pkg::THRESH_RESET;
            for (int i = 0; i < 4; i++) begin
                r_dac[i] <= '0;
            end
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                rmeter_pkg::CFG_THRESHOLD: r_thr    <= i_cfg_wdata[rmeter_pkg::UV_W-1:0];
                rmeter_pkg::CFG_DAC0:      r_dac[0] <= i_cfg_wdata[11:0];
                rmeter_pkg::CFG_DAC1:      r_dac[1] <= i_cfg_wdata[11:0];
                rmeter_pkg::CFG_DAC2:      r_dac[2] <= i_cfg_wdata[11:0];
                rmeter_pkg::CFG_DAC3:      r_dac[3] <= i_cfg_wdata[11:0];
                default: ;
            endcase
        end
    end

    // Sequencer next state
    always_comb begin
        n_mode      = r_mode;
        n_seq       = r_seq;
        n_level     = r_level;
        n_gain      = r_gain;
        n_ranging   = r_ranging;
        n_zero      = r_zero;
        n_pending   = r_pending;
        n_uv        = r_uv;
        e_emit      = 1'b0;
        e_kind      = rmeter_pkg::KIND_REQ;
        e_value     = '0;
        e_err       = rmeter_pkg::ERR_NONE;
        w_mem_req   = '0;
        w_mul_start = 1'b0;
        w_div_start = 1'b0;

        case (r_seq)
            rmeter_pkg::SEQ_IDLE: begin
                if (w_fire) begin
                    case (in_action)
                        rmeter_pkg::ACT_START: begin
                            n_mode    = rmeter_pkg::MODE_MEAS;
                            n_level   = '0;
                            n_gain    = '0;
                            n_ranging = 1'b0;
                            e_emit    = 1'b1;
                        end
                        rmeter_pkg::ACT_CAL: begin
                            n_mode    = rmeter_pkg::MODE_CAL;
                            n_level   = in_cal_level;
                            n_gain    = in_cal_gain;
                            n_ranging = 1'b0;
                            n_pending = in_cal_res;
                            e_emit    = 1'b1;
                        end
                        rmeter_pkg::ACT_READING: begin
                            if (r_mode == rmeter_pkg::MODE_IDLE) begin
                                // stray reading: dropped
                            end else if (in_fault) begin
                                n_mode = rmeter_pkg::MODE_IDLE;
                                e_emit = 1'b1;
                                e_kind = rmeter_pkg::KIND_ERR;
                                e_err  = rmeter_pkg::ERR_FAULT;
                            end else if (r_mode == rmeter_pkg::MODE_CAL) begin
                                n_mode = rmeter_pkg::MODE_IDLE;
                                e_emit = 1'b1;
                                if (in_ovf) begin
                                    e_kind = rmeter_pkg::KIND_ERR;
                                    e_err  = rmeter_pkg::ERR_CAL_OVF;
                                end else if (in_neg) begin
                                    e_kind = rmeter_pkg::KIND_ERR;
                                    e_err  = rmeter_pkg::ERR_CAL_NEG;
                                end else begin
                                    w_mem_req.we   = 1'b1;
                                    w_mem_req.addr = {r_level, r_gain};
                                    e_kind  = rmeter_pkg::KIND_CAL_DONE;
                                    e_value = rmeter_pkg::VALUE_W'(in_uv);
                                end
                            end else if (in_ovf) begin
                                // open circuit
                                n_mode  = rmeter_pkg::MODE_IDLE;
                                e_emit  = 1'b1;
                                e_kind  = rmeter_pkg::KIND_MEAS;
                                e_value = rmeter_pkg::OPEN_VALUE;
                            end else if (!r_ranging && w_below && !w_lvl_bound) begin
                                n_level = r_level + 1'b1;
                                e_emit  = 1'b1;
                            end else if (!w_below || w_gain_bound) begin
                                // range fixed: fetch calibration and compute
                                n_mode         = rmeter_pkg::MODE_IDLE;
                                n_uv           = in_uv;
                                w_mem_req.re   = 1'b1;
                                w_mem_req.addr = {r_level, r_gain};
                                n_seq          = rmeter_pkg::SEQ_LOAD;
                            end else begin
                                n_ranging = 1'b1;
                                n_gain    = r_gain + 1'b1;
                                e_emit    = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            rmeter_pkg::SEQ_LOAD: begin
                if (w_rd_reading == '0) begin
                    n_zero = 1'b1;
                    n_seq  = rmeter_pkg::SEQ_WAIT;
                end else begin
                    n_zero      = 1'b0;
                    w_mul_start = 1'b1;
                    n_seq       = rmeter_pkg::SEQ_MUL;
                end
            end
            rmeter_pkg::SEQ_MUL: begin
                if (w_mul_done) begin
                    w_div_start = 1'b1;
                    n_seq       = rmeter_pkg::SEQ_DIV;
                end
            end
            rmeter_pkg::SEQ_DIV: begin
                if (w_div_done) begin
                    n_seq = rmeter_pkg::SEQ_WAIT;
                end
            end
            rmeter_pkg::SEQ_WAIT: begin
                if (w_out_free) begin
                    e_emit = 1'b1;
                    n_seq  = rmeter_pkg::SEQ_IDLE;
                    if (r_zero) begin
                        e_kind  = rmeter_pkg::KIND_ERR;
                        e_err   = rmeter_pkg::ERR_ZERO_DIV;
                        e_value = rmeter_pkg::OPEN_VALUE;
                    end else begin
                        e_kind  = rmeter_pkg::KIND_MEAS;
                        e_value = {1'b0, w_quotient};
                    end
                end
            end
            default: n_seq = rmeter_pkg::SEQ_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= rmeter_pkg::MODE_IDLE;
            r_seq     <= rmeter_pkg::SEQ_IDLE;
            r_level   <= '0;
            r_gain    <= '0;
            r_ranging <= 1'b0;
            r_zero    <= 1'b0;
        end else begin
            r_mode    <= n_mode;
            r_seq     <= n_seq;
            r_level   <= n_level;
            r_gain    <= n_gain;
            r_ranging <= n_ranging;
            r_zero    <= n_zero;
        end
    end

    // Payload holding registers
    always_ff @(posedge i_clk) begin
        r_pending <= n_pending;
        r_uv      <= n_uv;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (e_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_emit) begin
            r_out_kind  <= e_kind;
            r_out_dac   <= (e_kind == rmeter_pkg::KIND_REQ) ? r_dac[n_level] : '0;
            r_out_gain  <= n_gain;
            r_out_level <= n_level;
            r_out_value <= e_value;
            r_out_err   <= e_err;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tdata  = {5'b0, r_out_err, r_out_value, r_out_level, r_out_gain, r_out_dac};

    // Calibration tables
    rmeter_cal_mem u_cal_mem (
        .i_clk        (i_clk),
        .i_req        (w_mem_req),
        .i_wr_res     (r_pending),
        .i_wr_reading (in_uv),
        .o_rd_res     (w_rd_res),
        .o_rd_reading (w_rd_reading)
    );

    // r * uV
    rmeter_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mul_start),
        .i_a       (w_rd_res),
        .i_b       (r_uv),
        .o_done    (w_mul_done),
        .o_product (w_product)
    );

    // (r * uV) / v
    rmeter_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_product),
        .i_divisor  (w_rd_reading),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

endmodule

`default_nettype wire

### hdl/rmeter_checker.sv
// ----------------------------------------------------------------------------
// rmeter_checker
// Port-level checks of the resistance meter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rmeter_checker (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  s_axis_tready,
    input  wire logic                                  m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    input  wire logic [rmeter_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  wire logic [1:0]                            m_axis_tuser
);

    // A stalled result holds its contents
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // No new request is taken while a result is stuck
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("request accepted while output blocked");

    // Error code is set exactly for error results
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            ((m_axis_tuser == rmeter_pkg::KIND_ERR) ==
             (m_axis_tdata[82:80] != rmeter_pkg::ERR_NONE)))
        else $error("error code does not match kind");

    // DAC code only accompanies reading requests
    a_dac_req_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != rmeter_pkg::KIND_REQ) |->
            (m_axis_tdata[11:0] == 12'd0))
        else $error("DAC code on non-request result");

endmodule

bind autorange_resistance_meter rmeter_checker u_rmeter_checker (.*);

`default_nettype wire

### dv/autorange_resistance_meter_tb.sv
// ----------------------------------------------------------------------------
// autorange_resistance_meter_tb
// Self-checking bench for the autoranging resistance meter sequencer.
// ----------------------------------------------------------------------------
// Requests go in on the slave stream in random bursts, and replies are taken
// from the master stream with a stall pattern of the bench's own. A behavioral
// copy of the sequencer and its calibration tables runs on every accepted
// request and queues the reply it expects. Each reply that arrives is checked
// field by field against the oldest one queued. A short list of hand-written
// requests opens the run, then four register settings with random traffic.
// ----------------------------------------------------------------------------

module autorange_resistance_meter_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rmeter_pkg::*;

    localparam logic [1:0] ACT_NONE      = 2'd3;   // unused action, ignored by the block
    localparam int         SETTLE_CYCLES = 150;    // covers the multiply and divide
    localparam int         HOLD_CYCLES   = 400;    // long receiver hold-off

    typedef enum logic [1:0] {
        CHK_MODEL,      // reply taken from the bench's own sequencer copy
        CHK_TYPED,      // reply written into the row
        CHK_SILENT      // no reply allowed
    } chk_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] reading;
        logic        ovf;
        logic        fault;
        logic [1:0]  cal_level;
        logic [2:0]  cal_gain;
        logic [30:0] cal_res;
    } req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] dac;
        logic [2:0]  gain;
        logic [1:0]  level;
        logic [62:0] value;
        logic [2:0]  err;
    } reply_t;

    typedef struct packed {
        req_t   rq;
        chk_t   how;
        reply_t want;
    } row_t;

    // DUT ports
    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_wr_en;
    logic [2:0]             i_cfg_addr;
    logic [CFG_W-1:0]       i_cfg_wdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;     // reading, ovf, fault, cal level/gain/res
    logic [1:0]             s_axis_tuser;     // action
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;     // dac, gain, level, value, error
    logic [1:0]             m_axis_tuser;     // kind

    // Sequencer copy: registers, state and calibration tables
    logic [30:0] thresh;
    logic [11:0] dac_cfg [4];
    t_mode       sq_mode;
    logic [1:0]  sq_level;
    logic [2:0]  sq_gain;
    logic        sq_gain_phase;
    logic [30:0] held_res;
    logic [30:0] res_tab [TAB_DEPTH];
    logic [31:0] rd_tab [TAB_DEPTH];
    bit          tab_written [TAB_DEPTH];
    bit          unwritten_hit;

    reply_t reply_q [$];
    row_t   directed_rows [$];
    int     mismatch_cnt = 0;
    bit     hold_off_req = 1'b0;
    int     burst_left = 0;

    autorange_resistance_meter i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Reply carrying the current level and gain
    function automatic reply_t make_reply(logic [1:0] kind, logic [11:0] dac,
                                          logic [62:0] value, logic [2:0] err);
        reply_t rp;
        rp.kind  = kind;
        rp.dac   = dac;
        rp.gain  = sq_gain;
        rp.level = sq_level;
        rp.value = value;
        rp.err   = err;
        return rp;
    endfunction

    // One request through the sequencer copy
    task automatic autorange_step(input req_t rq, output bit has, output reply_t rp);
        logic [31:0] uv;
        logic [4:0]  ix;
        logic [63:0] prod;
        uv  = rq.reading[31] ? 32'd0 : rq.reading;
        has = 1'b1;
        rp  = '0;
        if (rq.action == ACT_START) begin
            sq_mode       = MODE_MEAS;
            sq_level      = 2'd0;
            sq_gain       = 3'd0;
            sq_gain_phase = 1'b0;
            rp = make_reply(KIND_REQ, dac_cfg[sq_level], '0, ERR_NONE);
            return;
        end
        if (rq.action == ACT_CAL) begin
            sq_mode       = MODE_CAL;
            sq_level      = rq.cal_level;
            sq_gain       = rq.cal_gain;
            sq_gain_phase = 1'b0;
            held_res      = rq.cal_res;
            rp = make_reply(KIND_REQ, dac_cfg[sq_level], '0, ERR_NONE);
            return;
        end
        if (rq.action != ACT_READING || sq_mode == MODE_IDLE) begin
            has = 1'b0;
            return;
        end
        if (rq.fault) begin
            sq_mode = MODE_IDLE;
            rp = make_reply(KIND_ERR, '0, '0, ERR_FAULT);
            return;
        end
        // calibration reading: store unless overrange or negative
        if (sq_mode == MODE_CAL) begin
            sq_mode = MODE_IDLE;
            if (rq.ovf) begin
                rp = make_reply(KIND_ERR, '0, '0, ERR_CAL_OVF);
            end else if (rq.reading[31]) begin
                rp = make_reply(KIND_ERR, '0, '0, ERR_CAL_NEG);
            end else begin
                ix = {sq_level, sq_gain};
                res_tab[ix]     = held_res;
                rd_tab[ix]      = rq.reading;
                tab_written[ix] = 1'b1;
                rp = make_reply(KIND_CAL_DONE, '0, 63'(uv), ERR_NONE);
            end
            return;
        end
        if (rq.ovf) begin
            sq_mode = MODE_IDLE;
            rp = make_reply(KIND_MEAS, '0, OPEN_VALUE, ERR_NONE);
            return;
        end
        // level search at gain zero
        if (!sq_gain_phase && uv < 32'(thresh) && sq_level < LEVEL_LAST) begin
            sq_level = sq_level + 2'd1;
            rp = make_reply(KIND_REQ, dac_cfg[sq_level], '0, ERR_NONE);
            return;
        end
        // range fixed: r * uV / v from the table
        if (uv >= 32'(thresh) || sq_gain >= GAIN_LAST) begin
            ix = {sq_level, sq_gain};
            if (!tab_written[ix])
                unwritten_hit = 1'b1;
            sq_mode = MODE_IDLE;
            if (rd_tab[ix] == 32'd0) begin
                rp = make_reply(KIND_ERR, '0, OPEN_VALUE, ERR_ZERO_DIV);
            end else begin
                prod = 64'(res_tab[ix]) * 64'(uv);
                rp = make_reply(KIND_MEAS, '0, 63'(prod / 64'(rd_tab[ix])), ERR_NONE);
            end
            return;
        end
        sq_gain_phase = 1'b1;
        sq_gain       = sq_gain + 3'd1;
        rp = make_reply(KIND_REQ, dac_cfg[sq_level], '0, ERR_NONE);
    endtask

    // A reading that would end on a never-calibrated entry becomes an overrange
    task automatic steer_clear_of_unwritten(inout req_t rq);
        t_mode      s_mode;
        logic [1:0] s_level;
        logic [2:0] s_gain;
        logic       s_phase;
        bit         has;
        reply_t     rp;
        if (rq.action != ACT_READING || sq_mode != MODE_MEAS)
            return;
        s_mode  = sq_mode;
        s_level = sq_level;
        s_gain  = sq_gain;
        s_phase = sq_gain_phase;
        unwritten_hit = 1'b0;
        autorange_step(rq, has, rp);
        sq_mode       = s_mode;
        sq_level      = s_level;
        sq_gain       = s_gain;
        sq_gain_phase = s_phase;
        if (unwritten_hit)
            rq.ovf = 1'b1;
    endtask

    // Reading value spread around the range threshold
    function automatic logic [31:0] pick_reading();
        int c;
        c = $urandom_range(0, 99);
        if (c < 8)  return {1'b1, 31'($urandom)};
        if (c < 12) return 32'd0;
        if (c < 16) return 32'h7FFF_FFFF;
        if (c < 22) return 32'($urandom_range(1, 1000));
        if (c < 28) return 32'(thresh);
        if (c < 34) return (thresh == 0) ? 32'd0 : 32'(thresh) - 32'd1;
        if (c < 67) return (thresh == 0) ? 32'd0 : 32'($urandom_range(0, 32'(thresh) - 1));
        return 32'($urandom_range(32'(thresh), 32'h7FFF_FFFF));
    endfunction

    // Mostly well-formed traffic, with restarts, faults and stray items mixed in
    function automatic req_t random_request();
        req_t rq;
        int   c;
        rq.reading   = $urandom;
        rq.ovf       = 1'($urandom_range(0, 1));
        rq.fault     = 1'($urandom_range(0, 1));
        rq.cal_level = 2'($urandom_range(0, 3));
        rq.cal_gain  = 3'($urandom_range(0, 7));
        rq.cal_res   = 31'($urandom);
        c = $urandom_range(0, 99);
        if (sq_mode == MODE_IDLE) begin
            if (c < 6)
                rq.action = $urandom_range(0, 1) ? ACT_NONE : ACT_READING;
            else if (c < 60)
                rq.action = ACT_START;
            else
                rq.action = ACT_CAL;
        end else begin
            if (c < 4)       rq.action = ACT_NONE;
            else if (c < 8)  rq.action = ACT_START;
            else if (c < 11) rq.action = ACT_CAL;
            else             rq.action = ACT_READING;
        end
        if (rq.action == ACT_READING) begin
            rq.reading = pick_reading();
            rq.fault   = ($urandom_range(0, 99) < 5);
            rq.ovf     = ($urandom_range(0, 99) < 5);
        end
        if (rq.action == ACT_CAL) begin
            c = $urandom_range(0, 9);
            if (c == 0)      rq.cal_res = '0;
            else if (c == 1) rq.cal_res = '1;
        end
        return rq;
    endfunction

    // Offer one request and hold it until taken, then queue its reply
    task automatic send_item(input req_t rq, input chk_t how, input reply_t want);
        bit     has;
        reply_t rp;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= rq.action;
        s_axis_tdata  <= {2'b00, rq.cal_res, rq.cal_gain, rq.cal_level,
                          rq.fault, rq.ovf, rq.reading};
        do @(posedge i_clk); while (!s_axis_tready);
        autorange_step(rq, has, rp);
        if (how == CHK_TYPED)
            reply_q.push_back(want);
        else if (how == CHK_MODEL && has)
            reply_q.push_back(rp);
        @(negedge i_clk);
    endtask

    // Sender bursts: valid stays up inside a burst, gaps fall between bursts
    task automatic pace();
        int gap;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    // Stop sending until every queued reply is in and the datapath has settled
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (reply_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write all five registers, block idle
    task automatic set_registers(input logic [30:0] thr, input logic [11:0] d0,
                                 input logic [11:0] d1, input logic [11:0] d2,
                                 input logic [11:0] d3);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= CFG_THRESHOLD;
        i_cfg_wdata <= thr;
        @(negedge i_clk);
        i_cfg_addr  <= CFG_DAC0;
        i_cfg_wdata <= CFG_W'(d0);
        @(negedge i_clk);
        i_cfg_addr  <= CFG_DAC1;
        i_cfg_wdata <= CFG_W'(d1);
        @(negedge i_clk);
        i_cfg_addr  <= CFG_DAC2;
        i_cfg_wdata <= CFG_W'(d2);
        @(negedge i_clk);
        i_cfg_addr  <= CFG_DAC3;
        i_cfg_wdata <= CFG_W'(d3);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        thresh     = thr;
        dac_cfg[0] = d0;
        dac_cfg[1] = d1;
        dac_cfg[2] = d2;
        dac_cfg[3] = d3;
    endtask

    // Random traffic until n requests that the block acts on have gone in
    task automatic run_phase(input int n, input int hold_at);
        req_t rq;
        bit   ignored;
        int   count;
        count = 0;
        while (count < n) begin
            rq = random_request();
            steer_clear_of_unwritten(rq);
            ignored = (rq.action == ACT_NONE) ||
                      (rq.action == ACT_READING && sq_mode == MODE_IDLE);
            send_item(rq, CHK_MODEL, '0);
            if (!ignored) begin
                count++;
                if (count == hold_at)
                    hold_off_req = 1'b1;
            end
            pace();
        end
    endtask

    task automatic add_row(input logic [1:0] act, input logic [31:0] reading,
                           input logic ovf, input logic fault, input logic [1:0] lvl,
                           input logic [2:0] gain, input logic [30:0] res, input chk_t how,
                           input logic [1:0] kind, input logic [11:0] dac,
                           input logic [2:0] wgain, input logic [1:0] wlevel,
                           input logic [62:0] value, input logic [2:0] err);
        row_t row;
        row.rq         = '{act, reading, ovf, fault, lvl, gain, res};
        row.how        = how;
        row.want       = '{kind, dac, wgain, wlevel, value, err};
        directed_rows.push_back(row);
    endtask

    // Stimulus
    initial begin
        req_t rq;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_addr    = CFG_THRESHOLD;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ACT_START;

        thresh        = THRESH_RESET;
        sq_mode       = MODE_IDLE;
        sq_level      = '0;
        sq_gain       = '0;
        sq_gain_phase = 1'b0;
        held_res      = '0;
        for (int i = 0; i < 4; i++)
            dac_cfg[i] = '0;
        for (int i = 0; i < TAB_DEPTH; i++) begin
            res_tab[i]     = '0;
            rd_tab[i]      = '0;
            tab_written[i] = 1'b0;
        end

        // Reset values, stray items, every error and the special cases
        add_row(ACT_READING, 32'd5, 1'b0, 1'b0, 2'd0, 3'd0, 31'd0, CHK_SILENT,
                KIND_REQ, 12'd0, 3'd0, 2'd0, 63'd0, ERR_NONE);
        add_row(ACT_NONE, '1, 1'b1, 1'b1, 2'd3, 3'd7, '1, CHK_SILENT,
                KIND_REQ, 12'd0, 3'd0, 2'd0, 63'd0, ERR_NONE);
        add_row(ACT_START, 32'd0, 1'b0, 1'b0, 2'd0, 3'd0, 31'd0, CHK_TYPED,
                KIND_REQ, 12'd0, 3'd0, 2'd0, 63'd0, ERR_NONE);
        add_row(ACT_READING, 32'd777, 1'b0, 1'b1, 2'd0, 3'd0, 31'd0, CHK_TYPED,
                KIND_ERR, 12'd0, 3'd0, 2'd0, 63'd0, ERR_FAULT);
        add_row(ACT_CAL, 32'd0, 1'b0, 1'b0, 2'd3, 3'd7, 31'h7FFF_FFFF, CHK_TYPED,
                KIND_REQ, 12'd0, 3'd7, 2'd3, 63'd0, ERR_NONE);
        add_row(ACT_READING, 32'h7FFF_FFFF, 1'b1, 1'b0, 2'd0, 3'd0, 31'd0, CHK_TYPED,
                KIND_ERR, 12'd0, 3'd7, 2'd3, 63'd0, ERR_CAL_OVF);
        add_row(ACT_CAL, 32'd0, 1'b0, 1'b0, 2'd3, 3'd7, 31'h7FFF_FFFF, CHK_TYPED,
                KIND_REQ, 12'd0, 3'd7, 2'd3, 63'd0, ERR_NONE);
        add_row(ACT_READING, 32'h8000_0000, 1'b0, 1'b0, 2'd0, 3'd0, 31'd0, CHK_TYPED,
                KIND_ERR, 12'd0, 3'd7, 2'd3, 63'd0, ERR_CAL_NEG);
        add_row(ACT_CAL, 32'd0, 1'b0, 1'b0, 2'd3, 3'd7, 31'h7FFF_FFFF, CHK_TYPED,
                KIND_REQ, 12'd0, 3'd7, 2'd3, 63'd0, ERR_NONE);
        add_row(ACT_READING, 32'h7FFF_FFFF, 1'b0, 1'b0, 2'd0, 3'd0, 31'd0, CHK_TYPED,
                KIND_CAL_DONE, 12'd0, 3'd7, 2'd3, 63'h7FFF_FFFF, ERR_NONE);
        // zero calibration reading at level 0, gain 0 leads to a zero divisor
        add_row(ACT_CAL, 32'd0, 1'b0, 1'b0, 2'd0, 3'd0, 31'd1000, CHK_TYPED,
                KIND_REQ, 12'd0, 3'd0, 2'd0, 63'd0, ERR_NONE);
        add_row(ACT_READING, 32'd0, 1'b0, 1'b0, 2'd0, 3'd0, 31'd0, CHK_TYPED,
                KIND_CAL_DONE, 12'd0, 3'd0, 2'd0, 63'd0, ERR_NONE);
        add_row(ACT_START, 32'd0, 1'b0, 1'b0, 2'd0, 3'd0, 31'd0, CHK_TYPED,
                KIND_REQ, 12'd0, 3'd0, 2'd0, 63'd0, ERR_NONE);
        add_row(ACT_READING, 32'd200000, 1'b0, 1'b0, 2'd0, 3'd0, 31'd0, CHK_TYPED,
                KIND_ERR, 12'd0, 3'd0, 2'd0, OPEN_VALUE, ERR_ZERO_DIV);
        // overrange while measuring reads as open
        add_row(ACT_START, 32'd0, 1'b0, 1'b0, 2'd0, 3'd0, 31'd0, CHK_TYPED,
                KIND_REQ, 12'd0, 3'd0, 2'd0, 63'd0, ERR_NONE);
        add_row(ACT_READING, 32'd42, 1'b1, 1'b0, 2'd0, 3'd0, 31'd0, CHK_TYPED,
                KIND_MEAS, 12'd0, 3'd0, 2'd0, OPEN_VALUE, ERR_NONE);
        // restart while busy, negative reading steps the level, then a result
        add_row(ACT_CAL, 32'd0, 1'b0, 1'b0, 2'd1, 3'd0, 31'd1000, CHK_MODEL,
                KIND_REQ, 12'd0, 3'd0, 2'd0, 63'd0, ERR_NONE);
        add_row(ACT_READING, 32'd50000, 1'b0, 1'b0, 2'd0, 3'd0, 31'd0, CHK_MODEL,
                KIND_REQ, 12'd0, 3'd0, 2'd0, 63'd0, ERR_NONE);
        add_row(ACT_START, 32'd0, 1'b0, 1'b0, 2'd0, 3'd0, 31'd0, CHK_MODEL,
                KIND_REQ, 12'd0, 3'd0, 2'd0, 63'd0, ERR_NONE);
        add_row(ACT_START, 32'd0, 1'b0, 1'b0, 2'd0, 3'd0, 31'd0, CHK_MODEL,
                KIND_REQ, 12'd0, 3'd0, 2'd0, 63'd0, ERR_NONE);
        add_row(ACT_READING, 32'hFFFF_FFFF, 1'b0, 1'b0, 2'd0, 3'd0, 31'd0, CHK_MODEL,
                KIND_REQ, 12'd0, 3'd0, 2'd0, 63'd0, ERR_NONE);
        add_row(ACT_READING, 32'h7FFF_FFFF, 1'b0, 1'b0, 2'd0, 3'd0, 31'd0, CHK_MODEL,
                KIND_REQ, 12'd0, 3'd0, 2'd0, 63'd0, ERR_NONE);

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].rq, directed_rows[i].how, directed_rows[i].want);
            pace();
        end
        drain();

        // Reset threshold, random DAC codes; calibrate every table entry first
        set_registers(THRESH_RESET, 12'($urandom), 12'($urandom), 12'($urandom),
                      12'($urandom));
        for (int ix = 0; ix < TAB_DEPTH; ix++) begin
            rq = random_request();
            rq.action    = ACT_CAL;
            rq.cal_level = 2'(ix >> 3);
            rq.cal_gain  = 3'(ix);
            send_item(rq, CHK_MODEL, '0);
            pace();
            rq = random_request();
            rq.action      = ACT_READING;
            rq.fault       = 1'b0;
            rq.ovf         = 1'b0;
            rq.reading     = pick_reading();
            rq.reading[31] = 1'b0;
            send_item(rq, CHK_MODEL, '0);
            pace();
        end
        run_phase(90, 0);
        drain();

        // Zero threshold: every reading is in range at the first level
        set_registers('0, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
        run_phase(100, 40);
        drain();

        // Top threshold: sequences can run through all levels and gains
        set_registers('1, 12'h000, 12'h001, 12'h800, 12'hFFF);
        run_phase(100, 0);
        drain();

        // Random threshold, in the everyday range half of the time
        set_registers($urandom_range(0, 1) ? 31'($urandom_range(0, 1_000_000))
                                           : 31'($urandom),
                      12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
        run_phase(100, 50);
        drain();

        if (mismatch_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Receiver: changing stall styles, plus a long hold-off on request
    initial begin
        int style;
        int left;
        style = 0;
        left  = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            if (left == 0) begin
                style = $urandom_range(0, 2);
                left  = $urandom_range(16, 128);
            end
            left--;
            case (style)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= 1'($urandom_range(0, 1));
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic check_field(input string name, input logic [62:0] want,
                               input logic [62:0] got);
        if (want !== got) begin
            mismatch_cnt++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Reply checker
    always @(posedge i_clk) begin
        reply_t got;
        reply_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind  = m_axis_tuser;
            got.dac   = m_axis_tdata[11:0];
            got.gain  = m_axis_tdata[14:12];
            got.level = m_axis_tdata[16:15];
            got.value = m_axis_tdata[79:17];
            got.err   = m_axis_tdata[82:80];
            if (reply_q.size() == 0) begin
                mismatch_cnt++;
                $display("%0t: reply with none expected, expected nothing, actual %0h",
                         $time, got);
            end else begin
                want = reply_q.pop_front();
                check_field("kind", 63'(want.kind), 63'(got.kind));
                check_field("dac_code", 63'(want.dac), 63'(got.dac));
                check_field("gain_select", 63'(want.gain), 63'(got.gain));
                check_field("level_index", 63'(want.level), 63'(got.level));
                check_field("value", want.value, got.value);
                check_field("error_code", 63'(want.err), 63'(got.err));
            end
        end
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

### sim.f
hdl/rmeter_pkg.sv
hdl/rmeter_cal_mem.sv
hdl/rmeter_mul.sv
hdl/rmeter_div.sv
hdl/autorange_resistance_meter.sv
hdl/rmeter_checker.sv
dv/autorange_resistance_meter_tb.sv
